// File: rtl/prc_pkg.sv
// Shared types, sizes and codes for the partition release and coalesce block.
package prc_pkg;

  // Table geometry
  localparam int MAX_PARTITIONS = 16;
  localparam int ADDR_BITS      = 16;
  localparam int IDX_W          = $clog2(MAX_PARTITIONS);
  localparam int CNT_W          = $clog2(MAX_PARTITIONS + 1);

  // Field widths
  localparam int ADDR_W   = 16;
  localparam int SIZE_W   = 17;
  localparam int USED_W   = 5;
  localparam int STATUS_W = 2;
  localparam int ADJ_W    = SIZE_W + 1;
  localparam int SUM_W    = SIZE_W + 2;

  localparam logic [SIZE_W-1:0] SIZE_LIMIT = '1;
  localparam logic [ADDR_W-1:0] ADDR_MASK  = ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

  // Request kinds
  localparam logic KIND_APPEND  = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_code_t;

  // Input transaction
  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] length;
    logic              free_flag;
  } request_t;

  // Output transaction
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   region_start;
    logic [SIZE_W-1:0]   region_size;
    logic [USED_W-1:0]   entries_used;
  } result_t;

  // One partition table entry
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] size;
    logic              free;
  } entry_t;

  // Datapath command encodings
  typedef enum logic [1:0] {RD_SCAN, RD_PREV, RD_NEXT, RD_SHIFT} rd_sel_t;
  typedef enum logic [1:0] {WR_NONE, WR_APPEND, WR_MERGE, WR_SHIFT} wr_sel_t;
  typedef enum logic [1:0] {RES_APPEND, RES_RELEASE, RES_MISS, RES_FULL} res_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic     load_in;
    rd_sel_t  rd_sel;
    wr_sel_t  wr_sel;
    logic     scan_inc;
    logic     cap_cur;
    logic     cap_prev;
    logic     cap_next;
    logic     shrink;
    logic     emit;
    res_sel_t res_sel;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic kind;
    logic full;
    logic empty;
    logic match;
    logic scan_first;
    logic scan_last;
    logic has_next;
    logic shift_more;
  } dp_status_t;

endpackage

// File: rtl/prc_datapath.sv
// Datapath: partition table memory, scan and shift pointers, merge arithmetic, result register.
module prc_datapath import prc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  dp_cmd_t    cmd,
  input  request_t   request,
  output dp_status_t stat,
  output logic       done,
  output result_t    result
);

  entry_t            mem [MAX_PARTITIONS];
  entry_t            rdata;
  entry_t            cur;
  entry_t            prev;
  entry_t            nxt;
  request_t          req;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  shift_ptr;
  logic [IDX_W-1:0]  scan_idx;
  logic [IDX_W-1:0]  found;
  logic              merge_prev;
  logic              merge_next;

  logic [1:0]        removed;
  logic [ADDR_W-1:0] req_addr;
  logic [CNT_W:0]    shift_src;
  logic [IDX_W-1:0]  base;
  logic [ADDR_W-1:0] merged_start;
  logic [SUM_W-1:0]  sum;
  logic [SIZE_W-1:0] total;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;
  logic              wr_en;

  // Merge arithmetic
  assign req_addr     = req.address & ADDR_MASK;
  assign removed      = {1'b0, merge_prev} + {1'b0, merge_next};
  assign shift_src    = {1'b0, shift_ptr} + (CNT_W + 1)'(removed);
  assign base         = merge_prev ? (found - IDX_W'(1)) : found;
  assign merged_start = merge_prev ? prev.start : cur.start;
  assign sum          = SUM_W'(cur.size)
                      + (merge_prev ? SUM_W'(prev.size) : SUM_W'(0))
                      + (merge_next ? SUM_W'(nxt.size) : SUM_W'(0));
  assign total        = (sum > SUM_W'(SIZE_LIMIT)) ? SIZE_LIMIT : sum[SIZE_W-1:0];

  // Status back to the controller
  assign stat.kind       = req.kind;
  assign stat.full       = (count == CNT_W'(MAX_PARTITIONS));
  assign stat.empty      = (count == '0);
  assign stat.match      = (rdata.start == req_addr);
  assign stat.scan_first = (scan_idx == '0);
  assign stat.scan_last  = ((CNT_W'(scan_idx) + CNT_W'(1)) == count);
  assign stat.has_next   = ((CNT_W'(found) + CNT_W'(1)) < count);
  assign stat.shift_more = (shift_src < {1'b0, count});

  // Select read address
  always_comb begin
    unique case (cmd.rd_sel)
      RD_SCAN:  rd_addr = scan_idx;
      RD_PREV:  rd_addr = found - IDX_W'(1);
      RD_NEXT:  rd_addr = found + IDX_W'(1);
      RD_SHIFT: rd_addr = shift_src[IDX_W-1:0];
      default:  rd_addr = scan_idx;
    endcase
  end

  // Select write address and data
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = shift_ptr[IDX_W-1:0];
    wr_data = rdata;
    unique case (cmd.wr_sel)
      WR_NONE: begin
        wr_en = 1'b0;
      end
      WR_APPEND: begin
        wr_addr = count[IDX_W-1:0];
        wr_data = '{start: req_addr, size: req.length, free: req.free_flag};
      end
      WR_MERGE: begin
        wr_addr = base;
        wr_data = '{start: merged_start, size: total, free: 1'b1};
      end
      WR_SHIFT: begin
        wr_addr = shift_ptr[IDX_W-1:0];
        wr_data = rdata;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Partition table memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  // Capture the transaction and the entries under test
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req <= request;
    end
    if (cmd.cap_cur) begin
      cur   <= rdata;
      found <= scan_idx;
    end
    if (cmd.cap_prev) begin
      prev <= rdata;
    end
    if (cmd.cap_next) begin
      nxt <= rdata;
    end
  end

  // Hold pointers, entry count and merge flags
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      scan_idx   <= '0;
      shift_ptr  <= '0;
      merge_prev <= 1'b0;
      merge_next <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        scan_idx   <= '0;
        merge_prev <= 1'b0;
        merge_next <= 1'b0;
      end else if (cmd.scan_inc) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
      if (cmd.cap_prev) begin
        merge_prev <= rdata.free &&
                      ((ADJ_W'(rdata.start) + ADJ_W'(rdata.size)) == ADJ_W'(cur.start));
      end
      if (cmd.cap_next) begin
        merge_next <= rdata.free &&
                      ((ADJ_W'(cur.start) + ADJ_W'(cur.size)) == ADJ_W'(rdata.start));
      end
      if (cmd.wr_sel == WR_APPEND) begin
        count <= count + CNT_W'(1);
      end else if (cmd.shrink) begin
        count <= count - CNT_W'(removed);
      end
      if (cmd.wr_sel == WR_MERGE) begin
        shift_ptr <= CNT_W'(base) + CNT_W'(1);
      end else if (cmd.wr_sel == WR_SHIFT) begin
        shift_ptr <= shift_ptr + CNT_W'(1);
      end
    end
  end

  // Drive the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  // Load the result transaction
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.entries_used <= USED_W'(count);
      unique case (cmd.res_sel)
        RES_APPEND: begin
          result.status       <= STATUS_DONE;
          result.region_start <= req_addr;
          result.region_size  <= req.length;
        end
        RES_RELEASE: begin
          result.status       <= STATUS_DONE;
          result.region_start <= merged_start;
          result.region_size  <= total;
        end
        RES_MISS: begin
          result.status       <= STATUS_MISS;
          result.region_start <= '0;
          result.region_size  <= '0;
        end
        RES_FULL: begin
          result.status       <= STATUS_FULL;
          result.region_start <= '0;
          result.region_size  <= '0;
        end
        default: begin
          result.status       <= STATUS_DONE;
          result.region_start <= '0;
          result.region_size  <= '0;
        end
      endcase
    end
  end

endmodule

// File: rtl/prc_ctrl.sv
// Controller: sequences append, scan, neighbor fetch, merge and table shift.
module prc_ctrl import prc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t stat,
  output logic       busy,
  output dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_PREV_RD,
    S_PREV_CAP,
    S_NEXT_RD,
    S_NEXT_CAP,
    S_MERGE,
    S_SHIFT_TEST,
    S_SHIFT_WR,
    S_EMIT
  } state_t;

  state_t   state;
  state_t   state_next;
  res_sel_t res_code;
  res_sel_t res_code_next;

  assign busy = (state != S_IDLE);

  // Decode next state and datapath commands
  always_comb begin
    state_next    = state;
    res_code_next = res_code;
    cmd           = '0;
    cmd.rd_sel    = RD_SCAN;
    cmd.wr_sel    = WR_NONE;
    cmd.res_sel   = res_code;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.kind == KIND_APPEND) begin
          if (stat.full) begin
            res_code_next = RES_FULL;
          end else begin
            cmd.wr_sel    = WR_APPEND;
            res_code_next = RES_APPEND;
          end
          state_next = S_EMIT;
        end else if (stat.empty) begin
          res_code_next = RES_MISS;
          state_next    = S_EMIT;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.rd_sel = RD_SCAN;
        state_next = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        priority if (stat.match) begin
          cmd.cap_cur = 1'b1;
          priority if (!stat.scan_first) begin
            state_next = S_PREV_RD;
          end else if (!stat.scan_last) begin
            state_next = S_NEXT_RD;
          end else begin
            state_next = S_MERGE;
          end
        end else if (stat.scan_last) begin
          res_code_next = RES_MISS;
          state_next    = S_EMIT;
        end else begin
          cmd.scan_inc = 1'b1;
          state_next   = S_SCAN_RD;
        end
      end
      S_PREV_RD: begin
        cmd.rd_sel = RD_PREV;
        state_next = S_PREV_CAP;
      end
      S_PREV_CAP: begin
        cmd.cap_prev = 1'b1;
        state_next   = stat.has_next ? S_NEXT_RD : S_MERGE;
      end
      S_NEXT_RD: begin
        cmd.rd_sel = RD_NEXT;
        state_next = S_NEXT_CAP;
      end
      S_NEXT_CAP: begin
        cmd.cap_next = 1'b1;
        state_next   = S_MERGE;
      end
      S_MERGE: begin
        cmd.wr_sel = WR_MERGE;
        state_next = S_SHIFT_TEST;
      end
      S_SHIFT_TEST: begin
        cmd.rd_sel = RD_SHIFT;
        if (stat.shift_more) begin
          state_next = S_SHIFT_WR;
        end else begin
          cmd.shrink    = 1'b1;
          res_code_next = RES_RELEASE;
          state_next    = S_EMIT;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_sel = WR_SHIFT;
        state_next = S_SHIFT_TEST;
      end
      S_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state and pending result code
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      res_code <= RES_APPEND;
    end else begin
      state    <= state_next;
      res_code <= res_code_next;
    end
  end

endmodule

// File: rtl/partition_release_coalesce.sv
// An append, a refused append or a release on an empty table goes from decode straight to
// the result strobe; a release that misses first scans the table one entry after another.
// A release that hits scans, fetches each neighbor that exists, merges and moves each later
// entry down, all through the single table read port.
// A new transaction is accepted at the edge that ends the strobe cycle, never while busy.
// Synchronous reset empties the table (entry count zero); the receiver cannot stall the strobe.
module partition_release_coalesce import prc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  request_t request,
  output logic     busy,
  output logic     done,
  output result_t  result
);

  dp_cmd_t    cmd;
  dp_status_t stat;

  // Sequence each transaction
  prc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Table storage and merge arithmetic
  prc_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .request (request),
    .stat    (stat),
    .done    (done),
    .result  (result)
  );

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for the partition table release and coalesce block.
module tb_top;
  import prc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1600;
  localparam int SETTLE_CYCLES = 4 * MAX_PARTITIONS + 16;
  localparam int MAX_REPORTS = 60;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  request_t request = '0;
  logic     busy;
  logic     done;
  result_t  result;

  // Mirror of the partition table, updated at each accepted transaction
  logic [ADDR_W-1:0] tbl_start [MAX_PARTITIONS];
  logic [SIZE_W-1:0] tbl_size [MAX_PARTITIONS];
  logic              tbl_free [MAX_PARTITIONS];
  int                tbl_count = 0;

  result_t pending_results[$];
  int mismatches = 0;
  int reports = 0;
  int n_append = 0;
  int n_full = 0;
  int n_release = 0;
  int n_miss = 0;
  int n_coalesce = 0;
  int n_ceiling = 0;

  partition_release_coalesce dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .request(request),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always #5 clk = ~clk;

  // Apply one transaction to the mirrored table and return the result it should give
  function automatic result_t update_partition_table(request_t req);
    result_t           res;
    logic [ADDR_W-1:0] addr;
    logic [SUM_W-1:0]  total;
    int                hit;
    int                base;
    int                removed;
    bit                join_prev;
    bit                join_next;
    res = '0;
    addr = req.address & ADDR_MASK;
    if (req.kind == KIND_APPEND) begin
      n_append++;
      if (tbl_count >= MAX_PARTITIONS) begin
        res.status = STATUS_FULL;
        n_full++;
      end else begin
        tbl_start[tbl_count] = addr;
        tbl_size[tbl_count] = req.length;
        tbl_free[tbl_count] = req.free_flag;
        tbl_count++;
        res.status = STATUS_DONE;
        res.region_start = addr;
        res.region_size = req.length;
      end
    end else begin
      n_release++;
      // Take the first entry in table order with a matching start
      hit = -1;
      for (int i = 0; i < tbl_count; i++) begin
        if (hit < 0 && tbl_start[i] == addr) hit = i;
      end
      if (hit < 0) begin
        res.status = STATUS_MISS;
        n_miss++;
      end else begin
        // Join a neighbor only when it is free and touches the entry, summed without wrap
        join_prev = hit > 0 && tbl_free[hit-1] &&
                    (ADJ_W'(tbl_start[hit-1]) + ADJ_W'(tbl_size[hit-1]) ==
                     ADJ_W'(tbl_start[hit]));
        join_next = hit + 1 < tbl_count && tbl_free[hit+1] &&
                    (ADJ_W'(tbl_start[hit]) + ADJ_W'(tbl_size[hit]) ==
                     ADJ_W'(tbl_start[hit+1]));
        total = SUM_W'(tbl_size[hit]);
        base = hit;
        removed = 0;
        if (join_prev) begin
          total += SUM_W'(tbl_size[hit-1]);
          base = hit - 1;
          removed++;
        end
        if (join_next) begin
          total += SUM_W'(tbl_size[hit+1]);
          removed++;
        end
        if (total > SUM_W'(SIZE_LIMIT)) total = SUM_W'(SIZE_LIMIT);
        if (removed > 0) n_coalesce++;
        if (total == SUM_W'(SIZE_LIMIT)) n_ceiling++;
        tbl_size[base] = total[SIZE_W-1:0];
        tbl_free[base] = 1'b1;
        // Close the gap left by absorbed entries
        for (int j = base + 1; j + removed < tbl_count; j++) begin
          tbl_start[j] = tbl_start[j+removed];
          tbl_size[j] = tbl_size[j+removed];
          tbl_free[j] = tbl_free[j+removed];
        end
        tbl_count -= removed;
        res.status = STATUS_DONE;
        res.region_start = tbl_start[base];
        res.region_size = total[SIZE_W-1:0];
      end
    end
    res.entries_used = USED_W'(tbl_count);
    return res;
  endfunction

  // Check each strobed result against the oldest pending prediction
  always @(posedge clk) begin
    result_t exp_res;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (reports < MAX_REPORTS) begin
          $display("%0t: unexpected result status=%0d start=%h size=%h used=%0d", $time,
                   result.status, result.region_start, result.region_size, result.entries_used);
          reports++;
        end
      end else begin
        exp_res = pending_results.pop_front();
        if (result.status !== exp_res.status || result.region_start !== exp_res.region_start ||
            result.region_size !== exp_res.region_size ||
            result.entries_used !== exp_res.entries_used) begin
          mismatches++;
          if (reports < MAX_REPORTS) begin
            $display("%0t: mismatch expected status=%0d start=%h size=%h used=%0d", $time,
                     exp_res.status, exp_res.region_start, exp_res.region_size,
                     exp_res.entries_used);
            $display("%0t:          actual   status=%0d start=%h size=%h used=%0d", $time,
                     result.status, result.region_start, result.region_size,
                     result.entries_used);
            reports++;
          end
        end
      end
    end
  end

  // Offer one transaction and hold it until the block takes it; start stays high
  task automatic send_request(request_t req);
    start <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    pending_results.insert(pending_results.size(), update_partition_table(req));
  endtask

  task automatic issue(logic kind, int addr, int len, logic free_mark);
    request_t req;
    req.kind = kind;
    req.address = ADDR_W'(addr);
    req.length = SIZE_W'(len);
    req.free_flag = free_mark;
    send_request(req);
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Hold off new transactions until every predicted result has come back
  task automatic wait_for_drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [SIZE_W-1:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return SIZE_W'(65536);
    if (r < 30) return SIZE_W'($urandom_range(0, 65536));
    return SIZE_W'($urandom_range(1, 2048));
  endfunction

  // Build mostly chained appends and releases of live starts, with some noise
  function automatic request_t make_random_request();
    request_t         req;
    logic [ADJ_W-1:0] tail;
    int               r;
    r = $urandom_range(0, 99);
    req.length = pick_length();
    req.free_flag = 1'($urandom_range(0, 1));
    req.address = ADDR_W'($urandom_range(0, 65535));
    if ((tbl_count < MAX_PARTITIONS && r < 45) || r < 5) begin
      req.kind = KIND_APPEND;
      if (tbl_count > 0) begin
        tail = ADJ_W'(tbl_start[tbl_count-1]) + ADJ_W'(tbl_size[tbl_count-1]);
        if (tail <= ADJ_W'(16'hFFFF) && $urandom_range(0, 9) < 8) req.address = tail[ADDR_W-1:0];
        else if ($urandom_range(0, 9) == 0)
          req.address = tbl_start[$urandom_range(0, tbl_count - 1)];
      end
    end else begin
      req.kind = KIND_RELEASE;
      if (tbl_count > 0 && $urandom_range(0, 99) < 85)
        req.address = tbl_start[$urandom_range(0, tbl_count - 1)];
    end
    return req;
  endfunction

  task automatic test_release_on_empty();
    issue(KIND_RELEASE, 16'h1234, 0, 1'b1);
  endtask

  // Merge both neighbors into one region that reaches the size ceiling
  task automatic test_merge_to_size_limit();
    issue(KIND_APPEND, 16'h0000, 16'h8000, 1'b1);
    issue(KIND_APPEND, 16'h8000, 16'h7FFF, 1'b0);
    issue(KIND_APPEND, 16'hFFFF, 65536, 1'b1);
    issue(KIND_RELEASE, 16'h8000, 65536, 1'b0);
  endtask

  // Release a start shared by two entries, the first already free
  task automatic test_duplicate_start();
    issue(KIND_APPEND, 16'h0000, 0, 1'b0);
    issue(KIND_RELEASE, 16'h0000, 0, 1'b1);
  endtask

  // Fill the table with a known layout, then append once more
  task automatic test_fill_until_full();
    logic [13:0] free_marks;
    int          addr;
    free_marks = 14'h0065;
    for (int k = 0; k < 14; k++) begin
      addr = (k < 8) ? 16'h1000 + 16 * k : 16'h2000 + 16 * (k - 8);
      issue(KIND_APPEND, addr, 16, free_marks[k]);
    end
    issue(KIND_APPEND, 16'hFFFF, 65536, 1'b1);
  endtask

  // Cover both merges, next only, prev only, gap and occupied neighbor, and a miss
  task automatic test_neighbor_cases();
    issue(KIND_RELEASE, 16'h1010, 16, 1'b0);
    issue(KIND_RELEASE, 16'h1040, 16, 1'b1);
    idle_cycles(3);
    issue(KIND_RELEASE, 16'h1070, 16, 1'b0);
    issue(KIND_RELEASE, 16'h2000, 16, 1'b1);
    issue(KIND_RELEASE, 16'hABCD, 16, 1'b0);
    wait_for_drain();
  endtask

  task automatic test_random_traffic(int n_items);
    int idle_pct;
    idle_pct = 0;
    for (int i = 0; i < n_items; i++) begin
      // Vary the idle rate per stretch, leaving some stretches without gaps
      if (i % 100 == 0) idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      send_request(make_random_request());
      if (i % 250 == 125) wait_for_drain();
      else if (i < n_items * 85 / 100 && $urandom_range(0, 99) < idle_pct)
        idle_cycles($urandom_range(1, 12));
    end
  endtask

  // Drain the remaining results and settle the verdict
  task automatic finish_run();
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d predicted results never arrived", $time, pending_results.size());
      mismatches += pending_results.size();
    end
    $display("Summary: %0d appends (%0d refused on a full table), %0d releases (%0d missed)",
             n_append, n_full, n_release, n_miss);
    $display("Summary: %0d releases coalesced neighbors, %0d regions hit the size ceiling",
             n_coalesce, n_ceiling);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_release_on_empty();
    test_merge_to_size_limit();
    test_duplicate_start();
    test_fill_until_full();
    test_neighbor_cases();
    test_random_traffic(RANDOM_ITEMS);
    finish_run();
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #7_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule
